@@ rtl/ashm_pkg.sv @@
// Shared types and constants for the converter scan and hysteresis monitor.
// No dependencies; imported by ashm_core and adc_scan_hysteresis_monitor.
`timescale 1ns / 1ps
`default_nettype none

package ashm_pkg;

    // round geometry
    localparam int NUM_SLOTS      = 12;
    localparam int SNAPSHOT_SLOTS = 7;
    localparam int NUM_BALANCE    = 4;

    localparam int SLOT_IDX_W = $clog2(NUM_SLOTS);
    localparam int SNAP_IDX_W = (SNAPSHOT_SLOTS > 1) ? $clog2(SNAPSHOT_SLOTS) : 1;
    localparam logic [SLOT_IDX_W-1:0] LAST_SLOT = SLOT_IDX_W'(NUM_SLOTS - 1);

    // field widths fixed by the interface
    localparam int SAMPLE_W    = 16;
    localparam int FUNC_W      = 2;
    localparam int READ_IDX_W  = 3;
    localparam int NEXT_SLOT_W = 4;
    localparam int FLAGS_W     = 4;

    // configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_BALANCE_LOW    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_BALANCE_HIGH   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_CV_SET_BELOW   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_CV_CLEAR_ABOVE = CFG_IDX_W'(3);

    localparam logic [SAMPLE_W-1:0] BALANCE_LOW_RST    = 16'd43690;
    localparam logic [SAMPLE_W-1:0] BALANCE_HIGH_RST   = 16'd48684;
    localparam logic [SAMPLE_W-1:0] CV_SET_BELOW_RST   = 16'd40000;
    localparam logic [SAMPLE_W-1:0] CV_CLEAR_ABOVE_RST = 16'd64000;

    // request function codes
    typedef enum logic [FUNC_W-1:0] {
        FUNC_CONV = 2'd0,
        FUNC_ACK  = 2'd1,
        FUNC_READ = 2'd2,
        FUNC_NOP  = 2'd3
    } ashm_func_t;

    typedef struct packed {
        logic [FUNC_W-1:0]     func;
        logic [SAMPLE_W-1:0]   sample;
        logic [READ_IDX_W-1:0] read_index;
    } ashm_in_t;

    typedef struct packed {
        logic [NEXT_SLOT_W-1:0] next_slot;
        logic                   ready_res;
        logic [FLAGS_W-1:0]     balance_flags;
        logic                   cv_mode;
        logic [SAMPLE_W-1:0]    read_value;
    } ashm_out_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] balance_low;
        logic [SAMPLE_W-1:0] balance_high;
        logic [SAMPLE_W-1:0] cv_set_below;
        logic [SAMPLE_W-1:0] cv_clear_above;
    } ashm_thresh_t;

endpackage

`default_nettype wire

@@ rtl/ashm_core.sv @@
// Scan state, round store, snapshot and hysteresis flags; one request per fire.
// Depends on ashm_pkg; the result is combinational, registered by the top level.
`timescale 1ns / 1ps
`default_nettype none

module ashm_core
    import ashm_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         fire,
    input  wire ashm_in_t     item,
    input  wire ashm_thresh_t thresh,
    output ashm_out_t         result
);

    logic [SLOT_IDX_W-1:0]  slot_index_reg, slot_index_next;
    logic                   started_reg, started_next;
    logic                   ready_reg, ready_next;
    logic [NUM_BALANCE-1:0] balance_reg, balance_next;
    logic                   cv_reg, cv_next;

    logic [SAMPLE_W-1:0] store_reg [NUM_SLOTS];
    logic [SAMPLE_W-1:0] snap_reg  [SNAPSHOT_SLOTS];
    logic [SAMPLE_W-1:0] view      [NUM_SLOTS];
    logic [SAMPLE_W-1:0] snap_fill [SNAPSHOT_SLOTS];

    logic is_conv, is_ack, is_read;
    logic store_we, round_end, finish;
    logic [SAMPLE_W-1:0] read_data;

    assign is_conv = (item.func == FUNC_CONV);
    assign is_ack  = (item.func == FUNC_ACK);
    assign is_read = (item.func == FUNC_READ);

    assign store_we  = fire && is_conv && started_reg;
    assign round_end = store_we && (slot_index_reg == LAST_SLOT);
    assign finish    = round_end && !ready_reg;

    // round contents as seen after this sample lands in the last slot
    for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_view
        assign view[g] = (g == NUM_SLOTS - 1) ? item.sample : store_reg[g];
    end

    // snapshot fill values, zero for slots past the round
    for (genvar g = 0; g < SNAPSHOT_SLOTS; g++) begin : g_fill
        if (g < NUM_SLOTS) begin : g_in
            assign snap_fill[g] = view[g];
        end else begin : g_out
            assign snap_fill[g] = '0;
        end
    end

    // balancer flags, clear test first
    for (genvar g = 0; g < NUM_BALANCE; g++) begin : g_bal
        if (SNAPSHOT_SLOTS + g < NUM_SLOTS) begin : g_in
            always_comb begin
                balance_next[g] = balance_reg[g];
                if (finish) begin
                    if (view[SNAPSHOT_SLOTS + g] < thresh.balance_low) begin
                        balance_next[g] = 1'b0;
                    end else if (view[SNAPSHOT_SLOTS + g] > thresh.balance_high) begin
                        balance_next[g] = 1'b1;
                    end
                end
            end
        end else begin : g_out
            assign balance_next[g] = balance_reg[g];
        end
    end

    // scan control, ready and constant-voltage flag
    always_comb begin
        slot_index_next = slot_index_reg;
        started_next    = started_reg;
        ready_next      = ready_reg;
        cv_next         = cv_reg;
        if (fire) begin
            priority if (is_conv && !started_reg) begin
                started_next    = 1'b1;
                slot_index_next = '0;
            end else if (round_end) begin
                slot_index_next = '0;
            end else if (store_we) begin
                slot_index_next = slot_index_reg + 1'b1;
            end else if (is_ack) begin
                ready_next = 1'b0;
            end
        end
        if (finish) begin
            ready_next = 1'b1;
            if (item.sample < thresh.cv_set_below) begin
                cv_next = 1'b1;
            end else if (item.sample > thresh.cv_clear_above) begin
                cv_next = 1'b0;
            end
        end
    end

    // snapshot read port
    always_comb begin
        read_data = '0;
        if (is_read && (32'(item.read_index) < SNAPSHOT_SLOTS)) begin
            read_data = snap_reg[SNAP_IDX_W'(item.read_index)];
        end
    end

    assign result.next_slot     = NEXT_SLOT_W'(slot_index_next);
    assign result.ready_res     = ready_next;
    assign result.balance_flags = FLAGS_W'(balance_next);
    assign result.cv_mode       = cv_next;
    assign result.read_value    = read_data;

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_index_reg <= '0;
            started_reg    <= 1'b0;
            ready_reg      <= 1'b0;
            balance_reg    <= '0;
            cv_reg         <= 1'b0;
        end else begin
            slot_index_reg <= slot_index_next;
            started_reg    <= started_next;
            ready_reg      <= ready_next;
            balance_reg    <= balance_next;
            cv_reg         <= cv_next;
        end
    end

    // round store, one slot per conversion once the scan has started
    always_ff @(posedge aclk) begin
        if (store_we) begin
            store_reg[slot_index_reg] <= item.sample;
        end
    end

    // snapshot copy at round end while ready is clear
    always_ff @(posedge aclk) begin
        if (finish) begin
            for (int i = 0; i < SNAPSHOT_SLOTS; i++) begin
                snap_reg[i] <= snap_fill[i];
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/adc_scan_hysteresis_monitor.sv @@
// A request moves from the input register through ashm_core into the result register,
// which drives m_valid. Throughput: one request per cycle unless m_ready stalls; the input
// register, the single ashm_core pass and the result register all advance together.
// Reset: synchronous active-low aresetn clears the scan state, flags and both
// pipeline valids and restores the threshold registers; stores stay unknown.
// Top level: handshake pipeline and threshold registers; depends on ashm_pkg, ashm_core.
`timescale 1ns / 1ps
`default_nettype none

module adc_scan_hysteresis_monitor
    import ashm_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire ashm_in_t              s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output ashm_out_t                  m_data,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    logic         in_valid_reg, in_valid_next;
    ashm_in_t     in_data_reg;
    logic         out_valid_reg, out_valid_next;
    ashm_out_t    out_data_reg;
    ashm_thresh_t thresh_reg, thresh_next;
    ashm_out_t    core_result;
    logic         advance, s_fire;

    // pipeline flow
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign s_fire  = s_valid && s_ready;

    assign in_valid_next  = s_fire || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !m_ready);

    assign m_valid   = out_valid_reg;
    assign m_data    = out_data_reg;
    assign cfg_ready = 1'b1;

    // threshold register writes
    always_comb begin
        thresh_next = thresh_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_BALANCE_LOW:    thresh_next.balance_low    = cfg_data;
                REG_BALANCE_HIGH:   thresh_next.balance_high   = cfg_data;
                REG_CV_SET_BELOW:   thresh_next.cv_set_below   = cfg_data;
                REG_CV_CLEAR_ABOVE: thresh_next.cv_clear_above = cfg_data;
                default:            thresh_next = thresh_reg;
            endcase
        end
    end

    ashm_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (advance),
        .item    (in_data_reg),
        .thresh  (thresh_reg),
        .result  (core_result)
    );

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg              <= 1'b0;
            out_valid_reg             <= 1'b0;
            thresh_reg.balance_low    <= BALANCE_LOW_RST;
            thresh_reg.balance_high   <= BALANCE_HIGH_RST;
            thresh_reg.cv_set_below   <= CV_SET_BELOW_RST;
            thresh_reg.cv_clear_above <= CV_CLEAR_ABOVE_RST;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            thresh_reg    <= thresh_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= core_result;
        end
    end

`ifndef SYNTH
    // a new request only enters while the held one moves on
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && in_valid_reg) |-> advance)
        else $error("input register overwritten while held");

    // an acknowledge always reports ready clear
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && (in_data_reg.func == FUNC_ACK)) |=> !out_data_reg.ready_res)
        else $error("ready still set after acknowledge");

    // reported slot stays within the round
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (32'(out_data_reg.next_slot) < NUM_SLOTS))
        else $error("next slot outside the round");

    // only a read request returns snapshot data
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && (in_data_reg.func != FUNC_READ)) |=> (out_data_reg.read_value == '0))
        else $error("read value on a non-read request");
`endif

endmodule

`default_nettype wire
